// ===== rtl/mktc_pkg.sv =====
package mktc_pkg;

    // Default build parameters
    localparam int MAX_ORDER_DEF   = 6;
    localparam int COUNT_WIDTH_DEF = 32;

    // Configuration register
    localparam int CFG_W = 3;
    localparam logic [CFG_W-1:0] ORDER_RESET = 3'd3;

    // Input word fields
    localparam int READ_IDX_W = 12;
    localparam int OUT_W      = 32;

    // Op codes
    localparam logic OP_BASE = 1'b0;
    localparam logic OP_READ = 1'b1;

    // Queue depths
    localparam int CMDQ_DEPTH = 4;
    localparam int RESQ_DEPTH = 2;

    typedef struct packed {
        logic                  op;
        logic                  base_valid;
        logic [1:0]            base;
        logic                  last_in_sequence;
        logic [READ_IDX_W-1:0] read_index;
    } t_in_word;

    typedef struct packed {
        logic [OUT_W-1:0] context_count;
        logic [OUT_W-1:0] next_count_0;
        logic [OUT_W-1:0] next_count_1;
        logic [OUT_W-1:0] next_count_2;
        logic [OUT_W-1:0] next_count_3;
        logic [OUT_W-1:0] row_total;
        logic [OUT_W-1:0] grand_total;
    } t_out_word;

    localparam int OUT_WORD_W = $bits(t_out_word);

    // Width of a front-to-back command: read flag, k-mer update, transition update
    function automatic int cmd_width(input int max_order);
        return 4 * max_order + 5;
    endfunction

endpackage

// ===== rtl/markov_kmer_transition_counter.sv =====
// Markov k-mer transition counter.
// Input channel (push/full): one word per accepted push; op selects a base of a
// sequence or a read of one context row. Result channel (empty/pop): one word
// per read, in order; base words produce no result.
// Config: i_cfg_we/i_cfg_data write the order register; write only while idle.
// Throughput: one input word per cycle while full is low. A word that also settles
// a deferred refill count needs two commands in the update stage, since the
// k-mer memory has one read-modify-write port; full stays high after such a
// word until its second command is queued.
// Read path: a read word's command passes through the command queue and the
// update stage into the result queue, behind any earlier queued commands.
// Reset: the order register returns to 3, sequence state clears, and a sweep
// over all 2^(2*MAX_ORDER) entries (4096 at default) zeroes the count memories;
// full stays high during the sweep.
// Stall: when the result queue is full a read in the update stage holds, the
// command queue between the classifier and the update stage fills, then full rises.
module markov_kmer_transition_counter
    import mktc_pkg::*;
#(
    parameter int MAX_ORDER   = MAX_ORDER_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  logic             push,
    input  t_in_word         i_in_word,
    output logic             full,
    output logic             empty,
    input  logic             pop,
    output t_out_word        o_out_word
);

    localparam int CMD_W = cmd_width(MAX_ORDER);

    logic             busy;
    logic             cmd_push;
    logic [CMD_W-1:0] cmd_wr;
    logic             cmd_full;
    logic             cmd_pop;
    logic             cmd_empty;
    logic [CMD_W-1:0] cmd_rd;
    logic             res_push;
    t_out_word        res_wr;
    logic             res_full;

    // Classifier and sequence state
    mktc_front #(
        .MAX_ORDER(MAX_ORDER)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_push     (push),
        .i_in_word  (i_in_word),
        .o_full     (full),
        .i_busy     (busy),
        .o_cmd_push (cmd_push),
        .o_cmd      (cmd_wr),
        .i_cmd_full (cmd_full)
    );

    // Command queue
    mktc_fifo #(
        .WIDTH(CMD_W),
        .DEPTH(CMDQ_DEPTH)
    ) u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  (cmd_wr),
        .o_full  (cmd_full),
        .i_pop   (cmd_pop),
        .o_empty (cmd_empty),
        .o_data  (cmd_rd)
    );

    // Count memories and update stage
    mktc_back #(
        .MAX_ORDER  (MAX_ORDER),
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .o_busy      (busy),
        .i_cmd_empty (cmd_empty),
        .o_cmd_pop   (cmd_pop),
        .i_cmd       (cmd_rd),
        .o_res_push  (res_push),
        .o_res       (res_wr),
        .i_res_full  (res_full)
    );

    // Result queue
    mktc_fifo #(
        .WIDTH(OUT_WORD_W),
        .DEPTH(RESQ_DEPTH)
    ) u_resq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_wr),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (o_out_word)
    );

endmodule

// ===== rtl/mktc_fifo.sv =====
module mktc_fifo
    import mktc_pkg::*;
#(
    parameter int WIDTH = OUT_WORD_W,
    parameter int DEPTH = RESQ_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    // Pointer wrap at DEPTH
    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (int'(p) == DEPTH - 1) ? '0 : p + PTR_W'(1);
    endfunction

    // Storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (do_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

// ===== rtl/mktc_front.sv =====
module mktc_front
    import mktc_pkg::*;
#(
    parameter int MAX_ORDER = MAX_ORDER_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [CFG_W-1:0]                i_cfg_data,
    input  logic                            i_push,
    input  t_in_word                        i_in_word,
    output logic                            o_full,
    input  logic                            i_busy,
    output logic                            o_cmd_push,
    output logic [cmd_width(MAX_ORDER)-1:0] o_cmd,
    input  logic                            i_cmd_full
);

    localparam int IDX_W = 2 * MAX_ORDER;
    localparam int ORD_W = $clog2(MAX_ORDER + 1);

    typedef struct packed {
        logic             is_read;
        logic             kmer_vld;
        logic [IDX_W-1:0] kmer_addr;
        logic             trans_vld;
        logic [IDX_W-1:0] trans_addr;
        logic [1:0]       trans_base;
    } t_cmd;

    logic [CFG_W-1:0] r_order;
    logic [IDX_W-1:0] r_ctx;
    logic [ORD_W-1:0] r_run;
    logic             r_first;
    logic             r_defer;
    logic             r_extra_vld;
    t_cmd             r_extra;

    logic [IDX_W-1:0] n_ctx;
    logic [ORD_W-1:0] n_run;
    logic             n_first;
    logic             n_defer;

    logic [ORD_W-1:0] eff_order;
    logic [IDX_W-1:0] cmask;
    logic [IDX_W-1:0] ctx;
    logic [IDX_W-1:0] shifted;
    logic [ORD_W-1:0] run_inc;
    logic             accept;
    logic             is_read;
    t_cmd             cmd_a;
    t_cmd             cmd_b;
    t_cmd             cmd_rd;
    t_cmd             first_cmd;
    logic             have_a;
    logic             have_b;
    logic             push_now;

    assign is_read = (i_in_word.op == OP_READ);
    assign o_full  = i_busy || r_extra_vld || i_cmd_full;
    assign accept  = i_push && !o_full;

    // Effective order: zero acts as one, large values clamp
    always_comb begin
        if (r_order == '0) begin
            eff_order = ORD_W'(1);
        end else if (int'(r_order) > MAX_ORDER) begin
            eff_order = ORD_W'(MAX_ORDER);
        end else begin
            eff_order = ORD_W'(r_order);
        end
    end

    // Context mask, two bits per base
    always_comb begin
        cmask = '0;
        for (int i = 0; i < MAX_ORDER; i++) begin
            cmask[2*i +: 2] = (i < int'(eff_order)) ? 2'b11 : 2'b00;
        end
    end

    assign ctx     = r_ctx & cmask;
    assign shifted = ((ctx << 2) | IDX_W'(i_in_word.base)) & cmask;
    assign run_inc = r_run + ORD_W'(1);

    // Classify a base word into state update and back-end commands
    always_comb begin
        n_ctx   = ctx;
        n_run   = r_run;
        n_first = r_first;
        n_defer = 1'b0;

        // pending count of a refilled context
        cmd_a            = '0;
        cmd_a.kmer_vld   = r_defer;
        cmd_a.kmer_addr  = ctx;

        cmd_b            = '0;

        if (!i_in_word.base_valid) begin
            n_run = '0;
        end else if (r_run < eff_order) begin
            n_ctx = shifted;
            n_run = run_inc;
            if (run_inc == eff_order) begin
                if (!r_first) begin
                    cmd_b.kmer_vld  = 1'b1;
                    cmd_b.kmer_addr = shifted;
                    n_first         = 1'b1;
                end else if (!i_in_word.last_in_sequence) begin
                    n_defer = 1'b1;
                end
            end
        end else begin
            cmd_b.kmer_vld   = 1'b1;
            cmd_b.kmer_addr  = shifted;
            cmd_b.trans_vld  = 1'b1;
            cmd_b.trans_addr = ctx;
            cmd_b.trans_base = i_in_word.base;
            n_ctx            = shifted;
        end

        if (i_in_word.last_in_sequence) begin
            n_ctx   = '0;
            n_run   = '0;
            n_first = 1'b0;
            n_defer = 1'b0;
        end
    end

    // Read command
    always_comb begin
        cmd_rd            = '0;
        cmd_rd.is_read    = 1'b1;
        cmd_rd.kmer_addr  = IDX_W'(i_in_word.read_index);
        cmd_rd.trans_addr = IDX_W'(i_in_word.read_index);
    end

    assign have_a    = r_defer;
    assign have_b    = cmd_b.kmer_vld || cmd_b.trans_vld;
    assign first_cmd = is_read ? cmd_rd : (have_a ? cmd_a : cmd_b);
    assign push_now  = accept && (is_read || have_a || have_b);

    assign o_cmd_push = push_now || (r_extra_vld && !i_cmd_full);
    assign o_cmd      = r_extra_vld ? r_extra : first_cmd;

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order <= ORDER_RESET;
        end else if (i_cfg_we) begin
            r_order <= i_cfg_data;
        end
    end

    // Sequence state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctx   <= '0;
            r_run   <= '0;
            r_first <= 1'b0;
            r_defer <= 1'b0;
        end else if (accept && !is_read) begin
            r_ctx   <= n_ctx;
            r_run   <= n_run;
            r_first <= n_first;
            r_defer <= n_defer;
        end
    end

    // Second command of a word that needs two
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_extra_vld <= 1'b0;
        end else if (accept && !is_read && have_a && have_b) begin
            r_extra_vld <= 1'b1;
        end else if (r_extra_vld && !i_cmd_full) begin
            r_extra_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_extra <= cmd_b;
        end
    end

    a_defer_needs_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_defer |-> r_first)
        else $error("deferred count pending without a first context");

    a_push_from_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd_push && !r_extra_vld) |-> accept)
        else $error("command pushed without an accepted word");

endmodule

// ===== rtl/mktc_back.sv =====
module mktc_back
    import mktc_pkg::*;
#(
    parameter int MAX_ORDER   = MAX_ORDER_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    output logic                            o_busy,
    input  logic                            i_cmd_empty,
    output logic                            o_cmd_pop,
    input  logic [cmd_width(MAX_ORDER)-1:0] i_cmd,
    output logic                            o_res_push,
    output t_out_word                       o_res,
    input  logic                            i_res_full
);

    localparam int IDX_W   = 2 * MAX_ORDER;
    localparam int ENTRIES = 1 << IDX_W;
    localparam int CW      = COUNT_WIDTH;

    typedef struct packed {
        logic             is_read;
        logic             kmer_vld;
        logic [IDX_W-1:0] kmer_addr;
        logic             trans_vld;
        logic [IDX_W-1:0] trans_addr;
        logic [1:0]       trans_base;
    } t_cmd;

    typedef struct packed {
        logic [CW-1:0]        total;
        logic [3:0][CW-1:0]   next;
    } t_row;

    // Count memories
    logic [CW-1:0]    kmer_mem [ENTRIES];
    t_row             row_mem  [ENTRIES];

    logic             r_clr_busy;
    logic [IDX_W-1:0] r_clr_addr;

    logic             r_s1_vld;
    t_cmd             r_s1_cmd;
    logic [CW-1:0]    r_kmer_q;
    t_row             r_row_q;

    logic             r_kbyp_vld;
    logic [IDX_W-1:0] r_kbyp_addr;
    logic [CW-1:0]    r_kbyp_data;
    logic             r_tbyp_vld;
    logic [IDX_W-1:0] r_tbyp_addr;
    t_row             r_tbyp_data;

    logic [CW-1:0]    r_total;

    t_cmd             cmd_in;
    logic             s1_adv;
    logic [CW-1:0]    kmer_cur;
    logic [CW-1:0]    kmer_new;
    t_row             row_cur;
    t_row             row_new;
    logic             kmer_we;
    logic [IDX_W-1:0] kmer_wa;
    logic [CW-1:0]    kmer_wd;
    logic             row_we;
    logic [IDX_W-1:0] row_wa;
    t_row             row_wd;
    logic             kmer_upd;
    logic             row_upd;

    function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
        return (&v) ? v : v + CW'(1);
    endfunction

    assign cmd_in    = i_cmd;
    assign o_busy    = r_clr_busy;
    assign s1_adv    = r_s1_vld && !(r_s1_cmd.is_read && i_res_full);
    assign o_cmd_pop = !r_clr_busy && !i_cmd_empty && (!r_s1_vld || s1_adv);
    assign kmer_upd  = s1_adv && r_s1_cmd.kmer_vld;
    assign row_upd   = s1_adv && r_s1_cmd.trans_vld;

    // Current values, forwarding the write made at the read edge
    assign kmer_cur = (r_kbyp_vld && r_kbyp_addr == r_s1_cmd.kmer_addr) ? r_kbyp_data
                                                                         : r_kmer_q;
    assign row_cur  = (r_tbyp_vld && r_tbyp_addr == r_s1_cmd.trans_addr) ? r_tbyp_data
                                                                          : r_row_q;

    // Increments
    assign kmer_new = sat_inc(kmer_cur);

    always_comb begin
        row_new       = row_cur;
        row_new.total = sat_inc(row_cur.total);
        row_new.next[r_s1_cmd.trans_base] = sat_inc(row_cur.next[r_s1_cmd.trans_base]);
    end

    // Write port select: clearing sweep or update
    assign kmer_we = r_clr_busy || kmer_upd;
    assign kmer_wa = r_clr_busy ? r_clr_addr : r_s1_cmd.kmer_addr;
    assign kmer_wd = r_clr_busy ? '0 : kmer_new;
    assign row_we  = r_clr_busy || row_upd;
    assign row_wa  = r_clr_busy ? r_clr_addr : r_s1_cmd.trans_addr;
    assign row_wd  = r_clr_busy ? '0 : row_new;

    // K-mer count memory
    always_ff @(posedge i_clk) begin
        if (kmer_we) begin
            kmer_mem[kmer_wa] <= kmer_wd;
        end
        if (o_cmd_pop) begin
            r_kmer_q <= kmer_mem[cmd_in.kmer_addr];
        end
    end

    // Transition row memory
    always_ff @(posedge i_clk) begin
        if (row_we) begin
            row_mem[row_wa] <= row_wd;
        end
        if (o_cmd_pop) begin
            r_row_q <= row_mem[cmd_in.trans_addr];
        end
    end

    // Clearing sweep after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + IDX_W'(1);
            if (&r_clr_addr) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // Update stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (o_cmd_pop) begin
            r_s1_vld <= 1'b1;
        end else if (s1_adv) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_s1_cmd <= cmd_in;
        end
    end

    // Forwarding registers hold the latest write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kbyp_vld <= 1'b0;
            r_tbyp_vld <= 1'b0;
        end else begin
            if (kmer_upd) begin
                r_kbyp_vld <= 1'b1;
            end
            if (row_upd) begin
                r_tbyp_vld <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (kmer_upd) begin
            r_kbyp_addr <= r_s1_cmd.kmer_addr;
            r_kbyp_data <= kmer_new;
        end
        if (row_upd) begin
            r_tbyp_addr <= r_s1_cmd.trans_addr;
            r_tbyp_data <= row_new;
        end
    end

    // Grand total
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
        end else if (kmer_upd) begin
            r_total <= sat_inc(r_total);
        end
    end

    // Read result
    assign o_res_push          = s1_adv && r_s1_cmd.is_read;
    assign o_res.context_count = OUT_W'(kmer_cur);
    assign o_res.next_count_0  = OUT_W'(row_cur.next[0]);
    assign o_res.next_count_1  = OUT_W'(row_cur.next[1]);
    assign o_res.next_count_2  = OUT_W'(row_cur.next[2]);
    assign o_res.next_count_3  = OUT_W'(row_cur.next[3]);
    assign o_res.row_total     = OUT_W'(row_cur.total);
    assign o_res.grand_total   = OUT_W'(r_total);

    a_no_work_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !r_s1_vld)
        else $error("update stage active during clearing sweep");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && !s1_adv) |=> (r_s1_vld && $stable(r_s1_cmd)))
        else $error("stalled update stage lost its command");

    a_total_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_total >= $past(r_total)))
        else $error("grand total decreased");

endmodule

// ===== tb/sv/mktc_count_checker.sv =====
module mktc_count_checker
    import mktc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  logic             i_push,
    input  logic             i_full,
    input  t_in_word         i_in_word,
    input  logic             i_empty,
    input  logic             i_pop,
    input  t_out_word        i_out_word,
    output int               o_fail_count,
    output int               o_pending
);

    localparam int CTX_W   = 2 * MAX_ORDER_DEF;
    localparam int ENTRIES = 1 << CTX_W;

    // Shadow copy of the counter state
    logic [CFG_W-1:0] order_reg;
    logic [CTX_W-1:0] ctx_bases;
    int unsigned      run_len;
    bit               first_done;
    bit               count_pending;
    logic [OUT_W-1:0] kmer_tbl  [ENTRIES];
    logic [OUT_W-1:0] trans_tbl [4*ENTRIES];
    logic [OUT_W-1:0] row_tbl   [ENTRIES];
    logic [OUT_W-1:0] kmer_sum;

    // Rows owed by the block, oldest first
    t_out_word expected_rows [$];

    // Counts stick at all ones
    function automatic logic [OUT_W-1:0] bump(logic [OUT_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic void tally_kmer(logic [CTX_W-1:0] k);
        kmer_tbl[k] = bump(kmer_tbl[k]);
        kmer_sum    = bump(kmer_sum);
    endfunction

    function automatic void clear_sequence();
        ctx_bases     = '0;
        run_len       = 0;
        first_done    = 1'b0;
        count_pending = 1'b0;
    endfunction

    // Apply one accepted input word to the shadow state
    function automatic void absorb_word(t_in_word w);
        int unsigned      ord;
        logic [CTX_W-1:0] cmask;
        logic [CTX_W-1:0] prev;
        logic [CTX_W-1:0] nxt;
        t_out_word        row;
        ord   = (order_reg == 0) ? 1 :
                (order_reg > MAX_ORDER_DEF) ? MAX_ORDER_DEF : order_reg;
        cmask = CTX_W'((1 << (2 * ord)) - 1);
        if (w.op == OP_READ) begin
            row.context_count = kmer_tbl[w.read_index];
            row.next_count_0  = trans_tbl[{w.read_index, 2'd0}];
            row.next_count_1  = trans_tbl[{w.read_index, 2'd1}];
            row.next_count_2  = trans_tbl[{w.read_index, 2'd2}];
            row.next_count_3  = trans_tbl[{w.read_index, 2'd3}];
            row.row_total     = row_tbl[w.read_index];
            row.grand_total   = kmer_sum;
            expected_rows.push_back(row);
            return;
        end
        ctx_bases = ctx_bases & cmask;
        // refilled context waits for the next word of its sequence
        if (count_pending) begin
            tally_kmer(ctx_bases);
            count_pending = 1'b0;
        end
        if (!w.base_valid) begin
            run_len = 0;
        end else if (run_len < ord) begin
            ctx_bases = {ctx_bases[CTX_W-3:0], w.base} & cmask;
            run_len++;
            if (run_len == ord) begin
                if (!first_done) begin
                    tally_kmer(ctx_bases);
                    first_done = 1'b1;
                end else if (!w.last_in_sequence) begin
                    count_pending = 1'b1;
                end
            end
        end else begin
            prev = ctx_bases;
            nxt  = {ctx_bases[CTX_W-3:0], w.base} & cmask;
            tally_kmer(nxt);
            trans_tbl[{prev, w.base}] = bump(trans_tbl[{prev, w.base}]);
            row_tbl[prev]             = bump(row_tbl[prev]);
            ctx_bases                 = nxt;
        end
        if (w.last_in_sequence) clear_sequence();
    endfunction

    function automatic void compare_field(string name, logic [OUT_W-1:0] exp_v,
                                          logic [OUT_W-1:0] got_v);
        if (got_v !== exp_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, got_v);
            o_fail_count++;
        end
    endfunction

    function automatic void check_row(t_out_word got);
        t_out_word want;
        if (expected_rows.size() == 0) begin
            $error("result word with no read outstanding");
            o_fail_count++;
            return;
        end
        want = expected_rows.pop_front();
        compare_field("context_count", want.context_count, got.context_count);
        compare_field("next_count_0", want.next_count_0, got.next_count_0);
        compare_field("next_count_1", want.next_count_1, got.next_count_1);
        compare_field("next_count_2", want.next_count_2, got.next_count_2);
        compare_field("next_count_3", want.next_count_3, got.next_count_3);
        compare_field("row_total", want.row_total, got.row_total);
        compare_field("grand_total", want.grand_total, got.grand_total);
    endfunction

    // Outputs first, so a row leaving at this edge meets the older expectation
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            order_reg = ORDER_RESET;
            clear_sequence();
            for (int i = 0; i < ENTRIES; i++) begin
                kmer_tbl[i] = '0;
                row_tbl[i]  = '0;
            end
            for (int i = 0; i < 4 * ENTRIES; i++) trans_tbl[i] = '0;
            kmer_sum = '0;
            expected_rows.delete();
        end else begin
            if (i_pop && !i_empty) check_row(i_out_word);
            if (i_cfg_we) order_reg = i_cfg_data;
            if (i_push && !i_full) absorb_word(i_in_word);
        end
        o_pending = expected_rows.size();
    end

endmodule

// ===== tb/sv/tb_top.sv =====
module tb_top;
    import mktc_pkg::*;

    localparam int RESET_CYCLES    = 9;
    localparam int WATCHDOG_LIMIT  = 20000;
    localparam int RX_HOLD_CYCLES  = 400;
    localparam int SETTLE_CYCLES   = 20;
    localparam int TAIL_CYCLES     = 50;
    localparam int WORDS_PER_PHASE = 153;
    localparam int NUM_PHASES      = 8;

    logic             i_clk    = 1'b0;
    logic             i_rst_n  = 1'b0;
    logic             cfg_we   = 1'b0;
    logic [CFG_W-1:0] cfg_data = '0;
    logic             push     = 1'b0;
    t_in_word         in_word  = '0;
    logic             pop      = 1'b0;
    logic             full;
    logic             empty;
    t_out_word        out_word;
    int               fail_count;
    int               pending_rows;

    int          tx_idle_pct   = 0;
    int          rx_stall_pct  = 0;
    logic        rx_hold_go    = 1'b0;
    int unsigned order_now     = 3;
    int unsigned phase_words   = 0;
    int unsigned silent_cycles = 0;

    // Order written at the start of each phase; phase 0 runs on the reset value
    logic [CFG_W-1:0] order_plan [NUM_PHASES] =
        '{3'd3, 3'd1, 3'd6, 3'd0, 3'd7, 3'd2, 3'd5, 3'd4};
    int tx_plan [4] = '{0, 80, 0, 30};
    int rx_plan [4] = '{0, 0, 80, 30};

    always #2 i_clk = ~i_clk;

    markov_kmer_transition_counter u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data),
        .push       (push),
        .i_in_word  (in_word),
        .full       (full),
        .empty      (empty),
        .pop        (pop),
        .o_out_word (out_word)
    );

    mktc_count_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_data   (cfg_data),
        .i_push       (push),
        .i_full       (full),
        .i_in_word    (in_word),
        .i_empty      (empty),
        .i_pop        (pop),
        .i_out_word   (out_word),
        .o_fail_count (fail_count),
        .o_pending    (pending_rows)
    );

    // Result side: random stalls, plus one long hold-off
    initial begin : rx_side
        int unsigned hold_left;
        bit          hold_taken;
        hold_left  = 0;
        hold_taken = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_go && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left  = RX_HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else begin
                pop <= ($urandom_range(1, 100) > rx_stall_pct);
            end
        end
    end

    // Watchdog: cycles with no word moving on either side
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((push && !full) || (pop && !empty)) silent_cycles = 0;
            else silent_cycles++;
            if (silent_cycles >= WATCHDOG_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // Offer one word; push stays high into the next call when no gap is drawn
    task automatic send_word(t_in_word w);
        while ($urandom_range(1, 100) <= tx_idle_pct) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push    <= 1'b1;
        in_word <= w;
        do @(posedge i_clk); while (full);
        @(negedge i_clk);
        phase_words++;
    endtask

    task automatic send_base(bit valid, logic [1:0] b, bit last);
        t_in_word w;
        w.op               = OP_BASE;
        w.base_valid       = valid;
        w.base             = b;
        w.last_in_sequence = last;
        w.read_index       = READ_IDX_W'($urandom);
        send_word(w);
    endtask

    task automatic send_read(logic [READ_IDX_W-1:0] idx);
        t_in_word w;
        w.op               = OP_READ;
        w.base_valid       = 1'($urandom_range(0, 1));
        w.base             = 2'($urandom_range(0, 3));
        w.last_in_sequence = 1'($urandom_range(0, 1));
        w.read_index       = idx;
        send_word(w);
    endtask

    // Mostly contexts reachable at the current order, some anywhere
    function automatic logic [READ_IDX_W-1:0] pick_index();
        if ($urandom_range(0, 9) < 7)
            return READ_IDX_W'($urandom_range(0, (1 << (2 * order_now)) - 1));
        return READ_IDX_W'($urandom_range(0, (1 << READ_IDX_W) - 1));
    endfunction

    // Drop push, wait for every owed row, then let the pipeline go quiet
    task automatic settle(int unsigned cycles);
        push <= 1'b0;
        while (pending_rows != 0) @(negedge i_clk);
        repeat (cycles) @(negedge i_clk);
    endtask

    task automatic write_order(logic [CFG_W-1:0] v);
        settle(SETTLE_CYCLES);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(negedge i_clk);
        cfg_we    <= 1'b0;
        order_now = (v == 0) ? 1 : (v > MAX_ORDER_DEF) ? MAX_ORDER_DEF : v;
    endtask

    // One sequence: mostly clean, sometimes short or riddled with bad symbols
    task automatic send_random_sequence();
        int unsigned len;
        int unsigned bad_pct;
        bad_pct = ($urandom_range(0, 4) == 0) ? 35 : 5;
        if ($urandom_range(0, 7) == 0) len = $urandom_range(1, order_now);
        else len = $urandom_range(order_now, order_now + 18);
        for (int unsigned i = 0; i < len; i++) begin
            if ($urandom_range(0, 99) < 12) send_read(pick_index());
            send_base($urandom_range(1, 100) > bad_pct, 2'($urandom_range(0, 3)),
                      i == len - 1);
        end
    endtask

    initial begin : stimulus
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        // count memories are swept after reset with full held high
        do @(posedge i_clk); while (full);
        @(negedge i_clk);

        // Directed, order 3: empty rows at both ends of the index range
        send_read('0);
        send_read('1);
        // first context counted, one transition, break, refill counted on the last word
        send_base(1'b1, 2'd0, 1'b0);
        send_base(1'b1, 2'd1, 1'b0);
        send_base(1'b1, 2'd2, 1'b0);
        send_base(1'b1, 2'd3, 1'b0);
        send_base(1'b0, 2'd3, 1'b0);
        send_base(1'b1, 2'd2, 1'b0);
        send_base(1'b1, 2'd2, 1'b0);
        send_base(1'b1, 2'd2, 1'b0);
        send_base(1'b1, 2'd1, 1'b1);
        // sequence ending before its context fills
        send_base(1'b1, 2'd0, 1'b0);
        send_base(1'b1, 2'd1, 1'b1);
        // refill counted by an invalid symbol; a refill finished on the last symbol
        send_base(1'b1, 2'd0, 1'b0);
        send_base(1'b1, 2'd0, 1'b0);
        send_base(1'b1, 2'd0, 1'b0);
        send_base(1'b0, 2'd1, 1'b0);
        send_base(1'b1, 2'd2, 1'b0);
        send_base(1'b1, 2'd2, 1'b0);
        send_base(1'b1, 2'd2, 1'b0);
        send_base(1'b0, 2'd0, 1'b0);
        send_base(1'b1, 2'd1, 1'b0);
        send_base(1'b1, 2'd1, 1'b0);
        send_base(1'b1, 2'd1, 1'b1);
        send_read(12'd6);
        send_read(12'd42);

        // Long receiver hold-off while reads keep coming: the block backs up
        rx_hold_go <= 1'b1;
        repeat (24) send_read(pick_index());

        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p != 0) write_order(order_plan[p]);
            tx_idle_pct  = tx_plan[p % 4];
            rx_stall_pct <= rx_plan[p % 4];
            phase_words  = 0;
            while (phase_words < WORDS_PER_PHASE) send_random_sequence();
        end

        settle(TAIL_CYCLES);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
